// ===== sv/ccd_pkg.sv =====
// Shared types, codes and defaults of the clipped decimating convolver.
package ccd_pkg;

  localparam int DEFAULT_KERNEL_RADIUS = 2;
  localparam int DEFAULT_MAX_GRID      = 1025;

  localparam int IDX_W      = 11;
  localparam int TAP_IDX_W  = 7;
  localparam int DATA_W     = 16;
  localparam int ACC_W      = 40;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 11;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_SAMPLE = 2'd1,
    OP_FLUSH  = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRID_SIZE = 3'd0,
    CFG_DECIMATE  = 3'd1,
    CFG_ROW_FIRST = 3'd2,
    CFG_COL_FIRST = 3'd3,
    CFG_ROW_FINAL = 3'd4,
    CFG_COL_FINAL = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic [IDX_W-1:0] out_row;
    logic [IDX_W-1:0] out_col;
    logic             run_end;
  } meta_t;

  typedef struct packed {
    logic [IDX_W-1:0]        out_row;
    logic [IDX_W-1:0]        out_col;
    logic signed [ACC_W-1:0] filtered;
    logic                    run_end;
  } res_t;

endpackage

// ===== sv/ccd_if.sv =====
// Channel interfaces: input items, result items and configuration writes.
interface ccd_in_if import ccd_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [1:0]               op;
  logic [TAP_IDX_W-1:0]     tap_index;
  logic signed [DATA_W-1:0] tap_value;
  logic signed [DATA_W-1:0] sample;
  modport source(output valid, op, tap_index, tap_value, sample, input ready);
  modport sink(input valid, op, tap_index, tap_value, sample, output ready);
endinterface

interface ccd_out_if import ccd_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [IDX_W-1:0]        out_row;
  logic [IDX_W-1:0]        out_col;
  logic signed [ACC_W-1:0] filtered;
  logic                    run_end;
  modport source(output valid, out_row, out_col, filtered, run_end, input ready);
  modport sink(input valid, out_row, out_col, filtered, run_end, output ready);
endinterface

interface ccd_cfg_if import ccd_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ===== sv/ccd_mac.sv =====
// Three-stage multiply and adder tree over the kernel window.
module ccd_mac import ccd_pkg::*; #(
  parameter int KERNEL_RADIUS = DEFAULT_KERNEL_RADIUS
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  input  meta_t                    in_meta,
  input  logic signed [DATA_W-1:0] win  [2*KERNEL_RADIUS+1][2*KERNEL_RADIUS+1],
  input  logic signed [DATA_W-1:0] kern [(2*KERNEL_RADIUS+1)*(2*KERNEL_RADIUS+1)],
  output logic                     out_valid,
  output res_t                     out_res
);
  localparam int KW = 2 * KERNEL_RADIUS + 1;

  logic                       p_valid, s_valid;
  meta_t                      p_meta, s_meta;
  logic signed [2*DATA_W-1:0] prod [KW][KW];
  logic signed [ACC_W-1:0]    rsum [KW];
  logic signed [ACC_W-1:0]    rsum_next [KW];
  logic signed [ACC_W-1:0]    total_next;

  always_ff @(posedge clk) begin
    for (int j = 0; j < KW; j++) begin
      for (int i = 0; i < KW; i++) begin
        prod[j][i] <= win[j][i] * kern[j*KW+i];
      end
    end
    p_meta <= in_meta;
    rsum   <= rsum_next;
    s_meta <= p_meta;
    out_res.out_row  <= s_meta.out_row;
    out_res.out_col  <= s_meta.out_col;
    out_res.run_end  <= s_meta.run_end;
    out_res.filtered <= total_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid   <= 1'b0;
      s_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      p_valid   <= in_valid;
      s_valid   <= p_valid;
      out_valid <= s_valid;
    end
  end

  always_comb begin
    for (int j = 0; j < KW; j++) begin
      rsum_next[j] = '0;
      for (int i = 0; i < KW; i++) begin
        rsum_next[j] = rsum_next[j] + ACC_W'(prod[j][i]);
      end
    end
  end

  always_comb begin
    total_next = '0;
    for (int j = 0; j < KW; j++) begin
      total_next = total_next + rsum[j];
    end
  end

endmodule

// ===== sv/ccd_out_fifo.sv =====
// Result queue between the multiply pipeline and the output channel.
module ccd_out_fifo import ccd_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  res_t push_data,
  input  logic pop,
  output logic valid,
  output res_t data
);
  localparam int AW = $clog2(DEPTH);

  res_t          mem [DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [AW:0]   count;

  assign valid = (count != '0);
  assign data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      count <= count + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push && !pop |-> count < (AW+1)'(DEPTH))
    else $error("result queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> count != '0)
    else $error("result queue underflow");
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    !push && !pop |=> $stable(count))
    else $error("result queue count moved without request");

endmodule

// ===== sv/clipped_2d_convolver_decimating.sv =====
// Clipped, optionally decimating 2-D convolver: one grid sample per cycle while input is not
// held back. The row lines sit in one memory word per column (one lane per line, 2R+1 lanes);
// a sample reads the whole column and writes its own lane in the same cycle, and the window
// shifts one column per cycle. The final sample of a row holds input back while the window
// shifts R zero columns to finish that row's last centers. Results pass the multiply pipeline
// and then a result queue; apart from the row-end drain, input is held back only when the
// queue has no room left for the results one item can cause. Kernel words load one per item.
module clipped_2d_convolver_decimating import ccd_pkg::*; #(
  parameter int KERNEL_RADIUS = DEFAULT_KERNEL_RADIUS,
  parameter int MAX_GRID      = DEFAULT_MAX_GRID
) (
  input  logic      clk,
  input  logic      rst,
  ccd_in_if.sink    items,
  ccd_out_if.source results,
  ccd_cfg_if.sink   cfg
);
  localparam int KR       = KERNEL_RADIUS;
  localparam int KW       = 2 * KR + 1;
  localparam int KTAPS    = KW * KW;
  localparam int KIW      = $clog2(KTAPS);
  localparam int CW       = $clog2(MAX_GRID);
  localparam int IW       = $clog2(MAX_GRID + KR);
  localparam int SW       = (IW > IDX_W + 1 ? IW : IDX_W + 1) + 1;
  localparam int LW       = $clog2(KW);
  localparam int STW      = $clog2(KR + 1);
  localparam int OQ_DEPTH = 1 << $clog2(4 * (KR + 1));
  localparam int RSW      = $clog2(OQ_DEPTH + 1);

  // configuration
  logic [IDX_W-1:0] grid_size, row_first, col_first, row_final, col_final;
  logic             decimate;

  // scan position and line memory
  logic [IW-1:0]        scan_row, scan_col;
  logic [LW-1:0]        scan_lane;
  logic [KW*DATA_W-1:0] line_mem [MAX_GRID];
  logic [KW*DATA_W-1:0] line_rd;

  // accept-stage decode
  logic                 accept, is_scan, row_end;
  logic signed [SW-1:0] n_s, r_s, c_s, rc_s, fr_s, fc_s, cck;
  logic [KR:0]          emit;
  logic [IDX_W-1:0]     orow;

  // window stage
  logic                     b_valid, b_row_end, b_clear, b_dec, b_hold;
  logic [1:0]               b_op;
  logic [STW-1:0]           b_step;
  logic [KR:0]              b_emit;
  logic [LW-1:0]            b_lane;
  logic signed [SW-1:0]     b_r, b_n, b_ccbase, b_cc;
  logic [IDX_W-1:0]         b_orow;
  logic signed [DATA_W-1:0] b_sample, b_tap_value;
  logic [TAP_IDX_W-1:0]     b_tap_index;
  logic signed [DATA_W-1:0] col_in [KW];
  logic signed [DATA_W-1:0] win    [KW][KW];
  logic signed [DATA_W-1:0] kern   [KTAPS];

  logic            t1_valid, mac_valid;
  meta_t           t1_meta, b_meta;
  res_t            mac_res, head;
  logic [RSW-1:0]  reserved;
  logic            out_pop;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_size <= IDX_W'(1025);
      decimate  <= 1'b0;
      row_first <= '0;
      col_first <= '0;
      row_final <= IDX_W'(1024);
      col_final <= IDX_W'(1024);
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_GRID_SIZE: grid_size <= cfg.data;
        CFG_DECIMATE:  decimate  <= cfg.data[0];
        CFG_ROW_FIRST: row_first <= cfg.data;
        CFG_COL_FIRST: col_first <= cfg.data;
        CFG_ROW_FINAL: row_final <= cfg.data;
        CFG_COL_FINAL: col_final <= cfg.data;
        default: ;
      endcase
    end
  end

  // ---- accept stage ----
  assign b_hold      = b_valid && b_row_end && (b_step != STW'(KR));
  assign items.ready = !b_hold && (reserved <= RSW'(OQ_DEPTH - KR - 1));
  assign accept      = items.valid && items.ready;
  assign is_scan     = (items.op == OP_SAMPLE) || (items.op == OP_FLUSH);

  always_comb begin
    if (grid_size == '0) n_s = SW'(1);
    else if (SW'(grid_size) > SW'(MAX_GRID)) n_s = SW'(MAX_GRID);
    else n_s = $signed(SW'(grid_size));
    r_s  = $signed(SW'(scan_row));
    c_s  = ($signed(SW'(scan_col)) > n_s - SW'(1)) ? n_s - SW'(1) : $signed(SW'(scan_col));
    row_end = (c_s == n_s - SW'(1));
    rc_s = r_s - SW'(KR);
    fr_s = $signed(SW'(row_first)) + SW'(decimate & row_first[0]);
    fc_s = $signed(SW'(col_first)) + SW'(decimate & col_first[0]);
    orow = decimate ? rc_s[IDX_W:1] : rc_s[IDX_W-1:0];
    for (int k = 0; k <= KR; k++) begin
      cck = c_s - SW'(KR) + SW'(k);
      emit[k] = is_scan && (r_s >= SW'(KR)) && (rc_s < n_s) && (rc_s >= fr_s) &&
                (rc_s <= $signed(SW'(row_final))) && !(decimate && rc_s[0]) &&
                ((k == 0) || row_end) && (cck >= SW'(0)) && (cck >= fc_s) &&
                (cck <= $signed(SW'(col_final))) && !(decimate && cck[0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_row  <= '0;
      scan_col  <= '0;
      scan_lane <= '0;
    end else if (accept && is_scan) begin
      if (row_end) begin
        scan_col <= '0;
        if (r_s >= n_s + SW'(KR - 1)) begin
          scan_row  <= '0;
          scan_lane <= '0;
        end else begin
          scan_row  <= scan_row + 1'b1;
          scan_lane <= (scan_lane == LW'(KW - 1)) ? '0 : scan_lane + 1'b1;
        end
      end else begin
        scan_col <= IW'(c_s + SW'(1));
      end
    end
  end

  // line memory: read the whole column, write this row's lane
  always_ff @(posedge clk) begin
    if (accept && is_scan) begin
      line_rd <= line_mem[c_s[CW-1:0]];
      line_mem[c_s[CW-1:0]][scan_lane*DATA_W +: DATA_W] <=
        (items.op == OP_SAMPLE) ? items.sample : '0;
    end
  end

  // ---- window stage ----
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
      b_step  <= '0;
    end else if (b_hold) begin
      b_step <= b_step + 1'b1;
    end else begin
      b_valid <= accept;
      b_step  <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      b_op        <= items.op;
      b_row_end   <= is_scan && row_end;
      b_clear     <= (c_s == SW'(0));
      b_dec       <= decimate;
      b_emit      <= emit;
      b_lane      <= scan_lane;
      b_r         <= r_s;
      b_n         <= n_s;
      b_ccbase    <= c_s - SW'(KR);
      b_orow      <= orow;
      b_sample    <= (items.op == OP_SAMPLE) ? items.sample : '0;
      b_tap_index <= items.tap_index;
      b_tap_value <= items.tap_value;
    end
  end

  always_comb begin
    logic [LW:0]          lane;
    logic signed [SW-1:0] row;
    for (int j = 0; j < KW; j++) begin
      lane = {1'b0, b_lane} + (LW+1)'(j + 1);
      if (lane >= (LW+1)'(KW)) lane = lane - (LW+1)'(KW);
      row = b_r - SW'(2 * KR) + SW'(j);
      if (b_step != '0 || row < SW'(0) || row >= b_n) col_in[j] = '0;
      else if (j == KW - 1) col_in[j] = b_sample;
      else col_in[j] = $signed(line_rd[lane[LW-1:0]*DATA_W +: DATA_W]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < KW; j++)
        for (int i = 0; i < KW; i++) win[j][i] <= '0;
    end else if (b_valid && (b_op == OP_SAMPLE || b_op == OP_FLUSH)) begin
      for (int j = 0; j < KW; j++) begin
        for (int i = 0; i < KW - 1; i++) begin
          win[j][i] <= (b_clear && b_step == '0) ? '0 : win[j][i+1];
        end
        win[j][KW-1] <= col_in[j];
      end
    end
  end

  // kernel words are written in order with the window shifts
  always_ff @(posedge clk) begin
    if (b_valid && b_op == OP_LOAD && b_tap_index < TAP_IDX_W'(KTAPS))
      kern[b_tap_index[KIW-1:0]] <= b_tap_value;
  end

  assign b_cc            = b_ccbase + SW'(b_step);
  assign b_meta.out_row  = b_orow;
  assign b_meta.out_col  = b_dec ? b_cc[IDX_W:1] : b_cc[IDX_W-1:0];
  assign b_meta.run_end  = ((b_emit >> ({1'b0, b_step} + 1'b1)) == '0);

  always_ff @(posedge clk) begin
    if (rst) t1_valid <= 1'b0;
    else t1_valid <= b_valid && b_emit[b_step];
    t1_meta <= b_meta;
  end

  ccd_mac #(.KERNEL_RADIUS(KERNEL_RADIUS)) u_mac (
    .clk(clk), .rst(rst),
    .in_valid(t1_valid), .in_meta(t1_meta), .win(win), .kern(kern),
    .out_valid(mac_valid), .out_res(mac_res)
  );

  ccd_out_fifo #(.DEPTH(OQ_DEPTH)) u_fifo (
    .clk(clk), .rst(rst),
    .push(mac_valid), .push_data(mac_res),
    .pop(out_pop), .valid(results.valid), .data(head)
  );

  assign out_pop          = results.valid && results.ready;
  assign results.out_row  = head.out_row;
  assign results.out_col  = head.out_col;
  assign results.filtered = head.filtered;
  assign results.run_end  = head.run_end;

  // queue slots promised to accepted requests and not yet delivered
  always_ff @(posedge clk) begin
    if (rst) reserved <= '0;
    else reserved <= reserved + (accept ? RSW'($countones(emit)) : '0) - RSW'(out_pop);
  end

  a_reserve_bound: assert property (@(posedge clk) disable iff (rst)
    reserved <= RSW'(OQ_DEPTH))
    else $error("reserved slots exceed queue depth");
  a_output_reserved: assert property (@(posedge clk) disable iff (rst)
    results.valid |-> reserved != '0)
    else $error("result shown without reservation");
  a_drain_continues: assert property (@(posedge clk) disable iff (rst)
    b_hold |=> b_valid && b_step == $past(b_step) + 1'b1)
    else $error("row-end drain interrupted");

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench of the clipped decimating 2-D convolver.
module tb import ccd_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RAD       = DEFAULT_KERNEL_RADIUS;
  localparam int KW        = 2 * RAD + 1;
  localparam int KTAPS     = KW * KW;
  localparam int MAXG      = DEFAULT_MAX_GRID;
  localparam int SETTLE    = 20;
  localparam int CYCLE_CAP = 400000;
  localparam int ITEM_GOAL = 460;

  logic clk;
  logic rst;

  ccd_in_if  items_if();
  ccd_out_if res_if();
  ccd_cfg_if cfg_if();

  clipped_2d_convolver_decimating DUT (
    .clk     (clk),
    .rst     (rst),
    .items   (items_if),
    .results (res_if),
    .cfg     (cfg_if)
  );

  // predictor state
  logic signed [DATA_W-1:0] coef_mem [KTAPS];
  logic signed [DATA_W-1:0] line_mem [KW][MAXG];
  int unsigned scan_r, scan_c;
  int unsigned grid_reg, dec_reg, rfirst_reg, cfirst_reg, rfinal_reg, cfinal_reg;

  res_t conv_q[$];
  int   failures;
  int   items_sent;
  int   cycles;
  int   hold_left;
  bit   quiet;

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("clipped_2d_convolver_decimating verification failed");
      $finish;
    end
  end

  function automatic longint conv_sum(int rc, int cc, int n);
    longint acc;
    int r, c;
    acc = 0;
    for (int dr = -RAD; dr <= RAD; dr++) begin
      r = rc + dr;
      if (r < 0 || r >= n) continue;
      for (int dc = -RAD; dc <= RAD; dc++) begin
        c = cc + dc;
        if (c < 0 || c >= n) continue;
        acc += longint'(line_mem[r % KW][c]) * longint'(coef_mem[(dr + RAD) * KW + dc + RAD]);
      end
    end
    return acc;
  endfunction

  // Update the predicted kernel or advance the predicted scan for one accepted request, queue its results.
  task automatic predict_item(logic [1:0] op, logic [TAP_IDX_W-1:0] idx,
                              logic signed [DATA_W-1:0] val, logic signed [DATA_W-1:0] smp);
    int n, r, c, lo, hi, rc, fr, fc, cnt;
    bit row_end;
    res_t e;
    cnt = 0;
    if (op == OP_LOAD) begin
      if (idx < KTAPS) coef_mem[idx] = val;
      return;
    end
    if (op == OP_NONE) return;
    n = grid_reg;
    if (n < 1) n = 1;
    if (n > MAXG) n = MAXG;
    r = scan_r;
    c = scan_c;
    if (c > n - 1) c = n - 1;
    row_end = (c == n - 1);
    line_mem[r % KW][c] = (op == OP_SAMPLE) ? smp : '0;
    if (r >= RAD && r - RAD < n) begin
      rc = r - RAD;
      fr = rfirst_reg;
      fc = cfirst_reg;
      if (dec_reg != 0) begin
        fr += fr & 1;
        fc += fc & 1;
      end
      if (row_end) begin
        lo = (c >= RAD) ? c - RAD : 0;
        hi = n - 1;
      end else begin
        lo = c - RAD;
        hi = lo;
      end
      if (lo < 0) lo = 0;
      if (rc >= fr && rc <= int'(rfinal_reg) && !(dec_reg != 0 && rc[0])) begin
        for (int cc = lo; cc <= hi; cc++) begin
          if (cc < fc || cc > int'(cfinal_reg)) continue;
          if (dec_reg != 0 && cc[0]) continue;
          e.out_row  = (dec_reg != 0) ? IDX_W'(rc >> 1) : IDX_W'(rc);
          e.out_col  = (dec_reg != 0) ? IDX_W'(cc >> 1) : IDX_W'(cc);
          e.filtered = ACC_W'(conv_sum(rc, cc, n));
          e.run_end  = 1'b0;
          conv_q.push_back(e);
          cnt++;
        end
        if (cnt > 0) conv_q[conv_q.size() - 1].run_end = 1'b1;
      end
    end
    if (row_end) begin
      scan_c = 0;
      scan_r = (r >= n + RAD - 1) ? 0 : r + 1;
    end else begin
      scan_c = c + 1;
    end
  endtask

  task automatic send_item(logic [1:0] op, logic [TAP_IDX_W-1:0] idx,
                           logic signed [DATA_W-1:0] val, logic signed [DATA_W-1:0] smp);
    items_if.valid     <= 1'b1;
    items_if.op        <= op;
    items_if.tap_index <= idx;
    items_if.tap_value <= val;
    items_if.sample    <= smp;
    do @(posedge clk); while (!items_if.ready);
    predict_item(op, idx, val, smp);
    items_sent++;
    if (!quiet && $urandom_range(99) < 6) begin
      items_if.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  task automatic write_reg(cfg_idx_t idx, int unsigned value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= CFG_DATA_W'(value);
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    case (idx)
      CFG_GRID_SIZE: grid_reg   = value & 11'h7ff;
      CFG_DECIMATE:  dec_reg    = value & 1;
      CFG_ROW_FIRST: rfirst_reg = value & 11'h7ff;
      CFG_COL_FIRST: cfirst_reg = value & 11'h7ff;
      CFG_ROW_FINAL: rfinal_reg = value & 11'h7ff;
      CFG_COL_FINAL: cfinal_reg = value & 11'h7ff;
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Wait for every queued result, then let the pipeline settle.
  task automatic drain();
    items_if.valid <= 1'b0;
    while (conv_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic setup(int unsigned n, int unsigned dec, int unsigned rf, int unsigned cf,
                       int unsigned rl, int unsigned cl);
    drain();
    write_reg(CFG_GRID_SIZE, n);
    write_reg(CFG_DECIMATE, dec);
    write_reg(CFG_ROW_FIRST, rf);
    write_reg(CFG_COL_FIRST, cf);
    write_reg(CFG_ROW_FINAL, rl);
    write_reg(CFG_COL_FINAL, cl);
  endtask

  // One random request of a frame: mostly samples, some flush ticks and noise.
  task automatic send_random();
    int pick;
    pick = $urandom_range(99);
    if (pick < 84)
      send_item(OP_SAMPLE, '0, '0, DATA_W'($urandom));
    else if (pick < 92)
      send_item(OP_FLUSH, TAP_IDX_W'($urandom), DATA_W'($urandom), DATA_W'($urandom));
    else if (pick < 95)
      send_item(OP_NONE, TAP_IDX_W'($urandom), DATA_W'($urandom), DATA_W'($urandom));
    else if (pick < 98)
      send_item(OP_LOAD, TAP_IDX_W'($urandom_range(KTAPS - 1)), DATA_W'($urandom), '0);
    else
      send_item(OP_LOAD, TAP_IDX_W'($urandom_range(127, KTAPS)), DATA_W'($urandom), '0);
  endtask

  task automatic run_frame();
    do send_random(); while (!(scan_r == 0 && scan_c == 0));
  endtask

  task automatic test_kernel_load();
    for (int i = 0; i < KTAPS; i++)
      send_item(OP_LOAD, TAP_IDX_W'(i),
                (i == 0) ? 16'sh8000 : (i == 12) ? 16'sh7fff : DATA_W'($urandom), '0);
    send_item(OP_LOAD, TAP_IDX_W'(KTAPS), 16'sh1234, '0);
    send_item(OP_LOAD, 7'h7f, 16'shffff, '0);
    send_item(OP_NONE, 7'h7f, 16'shffff, 16'shffff);
  endtask

  task automatic test_extreme_samples();
    setup(3, 0, 0, 0, 2047, 2047);
    // samples at full scale, a flush tick inside the grid acts as zero
    send_item(OP_SAMPLE, '0, '0, 16'sh8000);
    send_item(OP_SAMPLE, '0, '0, 16'sh7fff);
    send_item(OP_FLUSH, '0, '0, 16'sh7fff);
    for (int i = 0; i < 6; i++) send_item(OP_SAMPLE, '0, '0, (i[0]) ? 16'sh8000 : 16'sh7fff);
    while (!(scan_r == 0 && scan_c == 0)) send_item(OP_SAMPLE, '0, '0, DATA_W'($urandom));
  endtask

  task automatic test_tiny_grid();
    setup(0, 0, 0, 0, 0, 0);
    run_frame();
    setup(1, 1, 0, 0, 1024, 1024);
    run_frame();
  endtask

  task automatic test_scan_past_grid();
    setup(2047, 0, 0, 0, 1024, 1024);
    repeat (10) send_item(OP_SAMPLE, '0, '0, DATA_W'($urandom));
    drain();
    write_reg(CFG_GRID_SIZE, 4);
    run_frame();
  endtask

  task automatic test_decimate();
    setup(7, 1, 1, 1, 6, 5);
    run_frame();
    setup(6, 1, 0, 0, 2047, 2047);
    run_frame();
    // first past final: nothing comes out
    setup(5, 0, 4, 3, 2, 1);
    run_frame();
  endtask

  task automatic test_backpressure();
    setup(8, 0, 0, 0, 1024, 1024);
    quiet = 1;
    hold_left = 300;
    run_frame();
    quiet = 0;
    drain();
    run_frame();
  endtask

  task automatic test_random();
    int unsigned n, rf, cf, rl, cl;
    while (items_sent < ITEM_GOAL) begin
      n = ($urandom_range(99) < 5) ? 0 : ($urandom_range(99) < 75) ? $urandom_range(1, 8)
                                                                     : $urandom_range(9, 12);
      rf = $urandom_range(0, n);
      cf = $urandom_range(0, n);
      rl = ($urandom_range(9) == 0) ? 2047 : $urandom_range(0, n + 1);
      cl = ($urandom_range(9) == 0) ? 1024 : $urandom_range(0, n + 1);
      if ($urandom_range(9) > 1) begin
        if (rl < rf) rl = rf + $urandom_range(0, 3);
        if (cl < cf) cl = cf + $urandom_range(0, 3);
      end
      setup(n, $urandom_range(1), rf, cf, rl, cl);
      quiet = ($urandom_range(7) == 0);
      run_frame();
      quiet = 0;
    end
  endtask

  always @(posedge clk) begin
    res_t e;
    if (!rst && res_if.valid && res_if.ready) begin
      if (conv_q.size() == 0) begin
        $error("unexpected result row %0d col %0d", res_if.out_row, res_if.out_col);
        failures++;
      end else begin
        e = conv_q.pop_front();
        if (res_if.out_row !== e.out_row) begin
          $error("out_row expected %0d actual %0d", e.out_row, res_if.out_row);
          failures++;
        end
        if (res_if.out_col !== e.out_col) begin
          $error("out_col expected %0d actual %0d", e.out_col, res_if.out_col);
          failures++;
        end
        if (res_if.filtered !== e.filtered) begin
          $error("filtered expected %0d actual %0d", e.filtered, res_if.filtered);
          failures++;
        end
        if (res_if.run_end !== e.run_end) begin
          $error("run_end expected %0d actual %0d", e.run_end, res_if.run_end);
          failures++;
        end
      end
    end
    if (hold_left > 0) begin
      res_if.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      res_if.ready <= quiet || ($urandom_range(99) >= 6);
    end
  end

  initial begin
    rst = 1'b1;
    items_if.valid = 1'b0;
    items_if.op = OP_NONE;
    items_if.tap_index = '0;
    items_if.tap_value = '0;
    items_if.sample = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = CFG_GRID_SIZE;
    cfg_if.data = '0;
    res_if.ready = 1'b0;
    failures = 0;
    items_sent = 0;
    cycles = 0;
    hold_left = 0;
    quiet = 0;
    for (int i = 0; i < KTAPS; i++) coef_mem[i] = '0;
    for (int l = 0; l < KW; l++)
      for (int c = 0; c < MAXG; c++) line_mem[l][c] = '0;
    scan_r = 0;
    scan_c = 0;
    grid_reg = 1025;
    dec_reg = 0;
    rfirst_reg = 0;
    cfirst_reg = 0;
    rfinal_reg = 1024;
    cfinal_reg = 1024;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_kernel_load();
    test_extreme_samples();
    test_tiny_grid();
    test_scan_past_grid();
    test_decimate();
    test_backpressure();
    test_random();

    drain();
    if (failures == 0 && conv_q.size() == 0)
      $display("clipped_2d_convolver_decimating verification clean");
    else
      $display("clipped_2d_convolver_decimating verification failed");
    $finish;
  end
endmodule
